/* rtl/cti_pkg.sv */
// Shared constants and types for the half-cosine trajectory evaluator.
// Depends on nothing; used by cosine_trajectory_interp.
package cti_pkg;

	// pi, CORDIC limit gain and one, all in Q30
	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [31:0] GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] ONE_Q30  = 32'd1073741824;

	// phase divider produces 31 quotient bits (0..2^30)
	localparam int PHASE_BITS = 31;
	// velocity divider produces 32 quotient bits before clamping
	localparam int VQ_BITS = 32;

	localparam int ATAN_ENTRIES = 30;
	localparam logic [30:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
		31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
		31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
		31'd1024,      31'd512,       31'd256,       31'd128,       31'd64,
		31'd32,        31'd16,        31'd8,         31'd4,         31'd2
	};

	// per-item context that rides along the pipeline
	typedef struct packed {
		logic               live;      // duration > 0
		logic               fold;      // phase past one half, cosine negated
		logic signed [31:0] start_pos;
		logic signed [31:0] end_pos;
		logic        [30:0] dur;       // duration magnitude (valid when live)
		logic signed [32:0] delta;
		logic signed [31:0] pos;       // finished position, filled late
	} ctx_t;

endpackage

/* rtl/cosine_trajectory_interp.sv */
// Half-cosine move profile evaluator, fully pipelined.
// Depends on cti_pkg (constants, atan table, context type).
//
// Usage:
//   Raise start with elapsed_time, move_duration, start_position and
//   end_position; the beat is taken at that clock edge (busy is always low,
//   so a new beat may enter every cycle). Each beat yields one result on
//   position_out / velocity_out, marked by done for exactly one cycle.
//   Pipeline stages, in order: 1 input stage, 31 stages of the phase
//   divider (one quotient bit each), 1 angle multiply, one CORDIC stage per
//   iteration, 3 multiply/saturate stages, 32 stages of the velocity
//   divider and 1 output stage. Throughput is one beat per cycle; the
//   divider stages set the depth.
//   Results leave in the order beats arrived. The receiver cannot stall:
//   it must take each result in its done cycle.
//   Reset (arst_n low) clears all valid bits; items in flight are dropped.
//   A nonpositive duration gives position = end and velocity = 0.
//   Outputs are saturated to the signed 32-bit range.
module cosine_trajectory_interp #(
	parameter int FRAC_BITS         = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] elapsed_time,
	input  logic signed [31:0] move_duration,
	input  logic signed [31:0] start_position,
	input  logic signed [31:0] end_position,
	output logic               done,
	output logic signed [31:0] position_out,
	output logic signed [31:0] velocity_out
);
	import cti_pkg::*;

	localparam int NC    = CORDIC_ITERATIONS;
	localparam int DSH   = 30 - FRAC_BITS;
	localparam int DEN_W = 31 + DSH;
	localparam int VW    = DEN_W + VQ_BITS + 1;
	localparam int LAT   = 69 + NC;

	assign busy = 1'b0;

	// ---------------- stage 1: clamp time, form delta
	logic        v_s1;
	ctx_t        ctx_s1;
	logic [30:0] tc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		ctx_s1.live      <= move_duration > 32'sd0;
		ctx_s1.fold      <= 1'b0;
		ctx_s1.start_pos <= start_position;
		ctx_s1.end_pos   <= end_position;
		ctx_s1.dur       <= move_duration[30:0];
		ctx_s1.delta     <= 33'(end_position) - 33'(start_position);
		ctx_s1.pos       <= '0;
		if (move_duration <= 32'sd0 || elapsed_time < 32'sd0)
			tc_s1 <= '0;
		else if (elapsed_time > move_duration)
			tc_s1 <= move_duration[30:0];
		else
			tc_s1 <= elapsed_time[30:0];
	end

	// ---------------- phase divider: r = floor(tc * 2^30 / dur), one bit a stage
	logic              pv  [0:PHASE_BITS];
	ctx_t              pc  [0:PHASE_BITS];
	logic [61:0]       pr  [0:PHASE_BITS];
	logic [PHASE_BITS-1:0] pq [0:PHASE_BITS];

	assign pv[0] = v_s1;
	assign pc[0] = ctx_s1;
	assign pr[0] = {tc_s1, 31'd0} >> 1;
	assign pq[0] = '0;

	for (genvar j = 0; j < PHASE_BITS; j++) begin : g_pdiv
		localparam int K = PHASE_BITS - 1 - j;
		logic [62:0] diff;
		assign diff = {1'b0, pr[j]} - ({32'd0, pc[j].dur} << K);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pv[j+1] <= 1'b0;
			else         pv[j+1] <= pv[j];
		end

		always_ff @(posedge clk) begin
			pc[j+1] <= pc[j];
			pr[j+1] <= diff[62] ? pr[j] : diff[61:0];
			pq[j+1] <= {pq[j][PHASE_BITS-2:0], ~diff[62]};
		end
	end

	// ---------------- angle stage: fold to [0, pi/2], scale by pi
	logic        v_sa;
	ctx_t        ctx_sa;
	logic signed [32:0] angle_sa;
	logic        fold_a;
	logic [29:0] rf_a;
	logic [62:0] ang_prod;
	ctx_t        ctx_a;

	always_comb begin
		fold_a   = pq[PHASE_BITS] > 31'(32'd1 << 29);
		rf_a     = fold_a ? 30'(31'(32'd1 << 30) - pq[PHASE_BITS])
		                  : pq[PHASE_BITS][29:0];
		ang_prod = 63'(rf_a) * 63'(PI_Q30) + 63'(64'd1 << 29);
		ctx_a      = pc[PHASE_BITS];
		ctx_a.fold = fold_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sa <= 1'b0;
		else         v_sa <= pv[PHASE_BITS];
	end

	always_ff @(posedge clk) begin
		ctx_sa   <= ctx_a;
		angle_sa <= $signed({1'b0, ang_prod[61:30]});
	end

	// ---------------- CORDIC rotation, one iteration a stage
	logic               cv [0:NC];
	ctx_t               cc [0:NC];
	logic signed [33:0] cx [0:NC];
	logic signed [33:0] cy [0:NC];
	logic signed [32:0] cz [0:NC];

	assign cv[0] = v_sa;
	assign cc[0] = ctx_sa;
	assign cx[0] = $signed({2'b00, GAIN_Q30});
	assign cy[0] = '0;
	assign cz[0] = angle_sa;

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		logic signed [32:0] at;
		assign at = $signed({2'b00, ATAN_Q30[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv[i+1] <= 1'b0;
			else         cv[i+1] <= cv[i];
		end

		always_ff @(posedge clk) begin
			cc[i+1] <= cc[i];
			if (!cz[i][32]) begin
				cx[i+1] <= cx[i] - (cy[i] >>> i);
				cy[i+1] <= cy[i] + (cx[i] >>> i);
				cz[i+1] <= cz[i] - at;
			end else begin
				cx[i+1] <= cx[i] + (cy[i] >>> i);
				cy[i+1] <= cy[i] - (cx[i] >>> i);
				cz[i+1] <= cz[i] + at;
			end
		end
	end

	// ---------------- M1: position and sine products
	logic               v_m1;
	ctx_t               ctx_m1;
	logic signed [67:0] pp_m1;
	logic signed [66:0] sp_m1;
	logic signed [33:0] cf_m1;
	logic signed [34:0] half_m1;

	always_comb begin
		cf_m1   = cc[NC].fold ? -cx[NC] : cx[NC];
		half_m1 = ($signed({3'b000, ONE_Q30}) - 35'(cf_m1)) >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m1 <= 1'b0;
		else         v_m1 <= cv[NC];
	end

	always_ff @(posedge clk) begin
		ctx_m1 <= cc[NC];
		pp_m1  <= 68'(cc[NC].delta) * 68'(half_m1);
		sp_m1  <= 67'(cy[NC]) * $signed({35'd0, PI_Q30});
	end

	// ---------------- M2: finish position, form velocity numerator
	logic               v_m2;
	ctx_t               ctx_m2;
	logic signed [64:0] num_m2;
	logic signed [67:0] off_m2;
	logic signed [68:0] sum_m2;
	logic signed [31:0] ps_m2;
	logic signed [31:0] pos_m2;
	ctx_t               ctx_c;

	always_comb begin
		off_m2 = (pp_m1 + 68'sd536870912) >>> 30;
		sum_m2 = 69'(ctx_m1.start_pos) + 69'(off_m2);
		if (sum_m2 > 69'sd2147483647)
			pos_m2 = 32'sh7FFFFFFF;
		else if (sum_m2 < -69'sd2147483648)
			pos_m2 = 32'sh80000000;
		else
			pos_m2 = sum_m2[31:0];
		ps_m2 = sp_m1[62:31];
		ctx_c     = ctx_m1;
		ctx_c.pos = ctx_m1.live ? pos_m2 : ctx_m1.end_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m2 <= 1'b0;
		else         v_m2 <= v_m1;
	end

	always_ff @(posedge clk) begin
		ctx_m2 <= ctx_c;
		num_m2 <= 65'(ctx_m1.delta) * 65'(ps_m2);
	end

	// ---------------- M3: magnitude, rounding bias, overflow check
	logic          v_m3;
	ctx_t          ctx_m3;
	logic          neg_m3;
	logic          ovf_m3;
	logic [VW-1:0] nn_m3;
	logic [63:0]   mag_c;
	logic [VW-1:0] den_c;
	logic [VW-1:0] nn_c;

	always_comb begin
		mag_c = num_m2[64] ? 64'(-num_m2) : 64'(num_m2);
		den_c = VW'(ctx_m2.dur) << DSH;
		nn_c  = VW'(mag_c) + (den_c >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m3 <= 1'b0;
		else         v_m3 <= v_m2;
	end

	always_ff @(posedge clk) begin
		ctx_m3 <= ctx_m2;
		neg_m3 <= num_m2[64];
		nn_m3  <= nn_c;
		ovf_m3 <= nn_c >= (den_c << VQ_BITS);
	end

	// ---------------- velocity divider, one quotient bit a stage
	logic              qv [0:VQ_BITS];
	ctx_t              qc [0:VQ_BITS];
	logic              qn [0:VQ_BITS];
	logic              qo [0:VQ_BITS];
	logic [VW-1:0]     qr [0:VQ_BITS];
	logic [VQ_BITS-1:0] qq [0:VQ_BITS];

	assign qv[0] = v_m3;
	assign qc[0] = ctx_m3;
	assign qn[0] = neg_m3;
	assign qo[0] = ovf_m3;
	assign qr[0] = nn_m3;
	assign qq[0] = '0;

	for (genvar j = 0; j < VQ_BITS; j++) begin : g_vdiv
		localparam int K = VQ_BITS - 1 - j;
		logic [VW:0] diff;
		assign diff = {1'b0, qr[j]} - ((VW+1)'(qc[j].dur) << (DSH + K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qv[j+1] <= 1'b0;
			else         qv[j+1] <= qv[j];
		end

		always_ff @(posedge clk) begin
			qc[j+1] <= qc[j];
			qn[j+1] <= qn[j];
			qo[j+1] <= qo[j];
			qr[j+1] <= diff[VW] ? qr[j] : diff[VW-1:0];
			qq[j+1] <= {qq[j][VQ_BITS-2:0], ~diff[VW]};
		end
	end

	// ---------------- output: sign, clamp, select special case
	logic        done_q;
	logic [31:0] pos_q;
	logic [31:0] vel_q;
	logic        big_o;
	logic [31:0] vel_o;

	always_comb begin
		big_o = qo[VQ_BITS] || qq[VQ_BITS][31];
		if (qn[VQ_BITS])
			vel_o = big_o ? 32'h80000000 : 32'(-qq[VQ_BITS]);
		else
			vel_o = big_o ? 32'h7FFFFFFF : qq[VQ_BITS];
		if (!qc[VQ_BITS].live)
			vel_o = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= qv[VQ_BITS];
	end

	always_ff @(posedge clk) begin
		pos_q <= qc[VQ_BITS].pos;
		vel_q <= vel_o;
	end

	assign done         = done_q;
	assign position_out = pos_q;
	assign velocity_out = vel_q;

	// ---------------- checks
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing after fixed latency");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching beat");

	a_idle_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(qv[VQ_BITS] && !qc[VQ_BITS].live) |=> (velocity_out == 32'sd0))
		else $error("nonpositive duration gave nonzero velocity");

endmodule

/* tb/cti_checker.sv */
// Checker for the half-cosine trajectory evaluator: watches accepted beats,
// predicts position and velocity, compares against done beats in order.
// Depends on cti_pkg for the Q30 constants and the atan table.
module cti_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] elapsed_time,
	input  logic signed [31:0] move_duration,
	input  logic signed [31:0] start_position,
	input  logic signed [31:0] end_position,
	input  logic               done,
	input  logic signed [31:0] position_out,
	input  logic signed [31:0] velocity_out,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import cti_pkg::*;

	localparam int FRAC = 16;
	localparam int ITERS = 16;

	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
	} profile_pt_t;

	profile_pt_t profile_q[$];

	function automatic longint sat_i32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// half-cosine profile point at one sample time
	function automatic profile_pt_t profile_point(longint t, longint dur, longint sp,
			longint ep);
		profile_pt_t pt;
		longint tc, ang, x, y, z, dx, dy, c, delta, half, ps, num;
		longint unsigned r, rf, mag, den, q;
		bit fold;
		if (dur <= 0) begin
			pt.pos = ep[31:0];
			pt.vel = '0;
			return pt;
		end
		tc = t < 0 ? 0 : (t > dur ? dur : t);
		r = (longint'(tc) << 30) / dur;
		fold = r > (64'd1 << 29);
		rf = fold ? (64'd1 << 30) - r : r;
		ang = longint'((rf * longint'(PI_Q30) + (64'd1 << 29)) >> 30);
		// rotation-mode CORDIC
		x = longint'(GAIN_Q30);
		y = 0;
		z = ang;
		for (int i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
			end
		end
		c = fold ? -x : x;
		delta = ep - sp;
		half = (longint'(ONE_Q30) - c) >>> 1;
		pt.pos = sat_i32(sp + ((delta * half + (64'sd1 <<< 29)) >>> 30));
		ps = (y * longint'(PI_Q30)) >>> 31;
		num = delta * ps;
		den = longint'(dur) << (30 - FRAC);
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		if (q > 64'h80000000)
			q = 64'h80000000;
		pt.vel = sat_i32(num < 0 ? -longint'(q) : longint'(q));
		return pt;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		pending_count = 0;
	end

	// predict on accepted beats, compare on done beats
	always @(posedge clk) begin
		profile_pt_t want;
		if (arst_n && done) begin
			result_count++;
			if (profile_q.size() == 0) begin
				$display("%0t unexpected result beat", $realtime);
				fail_count++;
			end else begin
				want = profile_q.pop_front();
				if (position_out !== want.pos)
					report_mismatch("position", position_out, want.pos);
				if (velocity_out !== want.vel)
					report_mismatch("velocity", velocity_out, want.vel);
			end
		end
		if (arst_n && start && !busy)
			profile_q.push_back(profile_point(elapsed_time, move_duration,
				start_position, end_position));
		pending_count = profile_q.size();
	end
endmodule

/* tb/tb_top.sv */
// Testbench top: drives beats into cosine_trajectory_interp and gives the
// verdict. Depends on cti_checker (tb) and the RTL with cti_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 85;
	localparam int WATCHDOG = 2000;

	logic clk, arst_n, start, busy, done;
	logic signed [31:0] elapsed_time, move_duration, start_position, end_position;
	logic signed [31:0] position_out, velocity_out;
	int fail_count, pending_count, result_count;
	int idle_cycles, beats_sent;

	cosine_trajectory_interp dut (.*);
	cti_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog on cycles with no beat either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic logic [31:0] edgy32();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	// an optional gap, then one beat, held until taken
	task automatic send_move(logic [31:0] t, logic [31:0] dur, logic [31:0] sp,
			logic [31:0] ep, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		elapsed_time <= t;
		move_duration <= dur;
		start_position <= sp;
		end_position <= ep;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	initial begin
		logic [31:0] dur, t, sp;
		idle_cycles = 0;
		beats_sent = 0;
		arst_n = 0;
		start = 0;
		elapsed_time = 0;
		move_duration = 0;
		start_position = 0;
		end_position = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: zero / negative duration, clamping, extremes, folds
		send_move(32'h10000, 32'h0, 32'h1234, 32'h5678, 0);
		send_move(32'h10000, 32'h80000000, 32'h1, 32'h7FFFFFFF, 0);
		send_move(32'hFFFF0000, 32'h20000, 32'h0, 32'h40000, 0);
		send_move(32'h7FFFFFFF, 32'h20000, 32'h0, 32'h40000, 0);
		send_move(32'h10000, 32'h20000, 32'h0, 32'h40000, 0);
		send_move(32'h8000, 32'h20000, 32'h0, 32'h40000, 0);
		send_move(32'h18000, 32'h20000, 32'hFFFF0000, 32'h40000, 0);
		send_move(32'h10000, 32'h20000, 32'h80000000, 32'h7FFFFFFF, 0);
		send_move(32'h10000, 32'h20000, 32'h7FFFFFFF, 32'h80000000, 0);
		send_move(32'h1, 32'h1, 32'h80000000, 32'h7FFFFFFF, 0);
		send_move(32'h0, 32'h1, 32'h80000000, 32'h7FFFFFFF, 0);
		send_move(32'h3FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
		send_move(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
		send_move(32'h7FFFFFFE, 32'h7FFFFFFF, 32'h0, 32'h0, 0);
		send_move(32'h1, 32'h3, 32'h7FFFFFFF, 32'h80000000, 0);
		send_move(32'h2, 32'h3, 32'hFFFFFFFF, 32'h0, 0);

		// hold off until the pipe drains
		start <= 0;
		while (pending_count != 0) @(negedge clk);

		// random: mostly in-range times on sane moves, some raw noise
		for (int n = 0; n < 1500; n++) begin
			bit gaps;
			gaps = (n / 200) % 2 == 1;
			if ($urandom_range(0, 4) == 0) begin
				send_move(edgy32(), edgy32(), edgy32(), edgy32(), gaps);
			end else begin
				dur = $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 30);
				if (dur == 0) dur = 1;
				t = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, dur);
				sp = $urandom;
				send_move(t, dur, sp, $urandom_range(0, 1) ? $urandom
					: sp + ($urandom >> $urandom_range(0, 31)), gaps);
			end
		end
		start <= 0;

		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		$display("covered %0d beats, %0d results: nonpositive durations, clamped times,",
			beats_sent, result_count);
		$display("both phase halves and saturating extremes, with and without gaps");
		if (fail_count == 0 && pending_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
